>>> hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, muted while reset is high
`define NCA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also runs during reset
`define NCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/nca_pkg.sv
// shared types and constants for the nearest centroid assignment block
// no dependencies
package nca_pkg;

  localparam int MAX_CENTROIDS = 16;
  localparam int MAX_POINTS    = 4096;
  localparam int CHANNEL_BITS  = 16;

  localparam int CENT_AW  = $clog2(MAX_CENTROIDS);
  localparam int PT_AW    = $clog2(MAX_POINTS);
  localparam int SLOT_W   = 12;
  localparam int CNT_W    = 5;
  localparam int DIST_W   = 2 * CHANNEL_BITS + 2;
  localparam int SQ_W     = 2 * CHANNEL_BITS + 1;
  localparam int TOTAL_W  = 13;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ASSIGN = 1'b1;

  typedef struct packed {
    logic                           opcode;
    logic [SLOT_W-1:0]              slot;
    logic signed [CHANNEL_BITS-1:0] chan_a;
    logic signed [CHANNEL_BITS-1:0] chan_b;
    logic signed [CHANNEL_BITS-1:0] chan_c;
    logic                           first_of_batch;
  } in_item_t;

  typedef struct packed {
    logic [CENT_AW-1:0] nearest;
    logic [DIST_W-1:0]  min_distance;
    logic               was_changed;
    logic [TOTAL_W-1:0] change_total;
  } out_item_t;

  typedef struct packed {
    logic signed [CHANNEL_BITS-1:0] a;
    logic signed [CHANNEL_BITS-1:0] b;
    logic signed [CHANNEL_BITS-1:0] c;
  } centroid_t;

  // controller to datapath
  typedef struct packed {
    logic               load_pt;
    logic               load_cent;
    logic               issue;
    logic               issue_first;
    logic [CENT_AW-1:0] issue_idx;
    logic               clr_wr;
    logic [PT_AW-1:0]   clr_addr;
    logic               finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
    logic out_full;
  } dp_status_t;

endpackage

>>> hdl/nca_datapath.sv
// datapath: centroid store, distance pipeline, running minimum, prior assignment
// memory, change counter and output register; uses nca_pkg
module nca_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  nca_pkg::in_item_t     in_data,
  input  nca_pkg::dp_cmd_t      cmd,
  output nca_pkg::dp_status_t   status,
  input  logic                  out_ready,
  output logic                  out_valid,
  output nca_pkg::out_item_t    out_data
);
  import nca_pkg::*;

  centroid_t          cent_mem [MAX_CENTROIDS];
  logic [CENT_AW-1:0] prior_mem [MAX_POINTS];

  // latched point
  centroid_t         pt;
  logic [SLOT_W-1:0] slot_q;
  logic              fob_q;
  logic [CENT_AW-1:0] prior_q;

  // pipeline
  logic               v0, v1, v2, v3;
  logic               f0, f1, f2, f3;
  logic [CENT_AW-1:0] i0, i1, i2, i3;
  centroid_t          cent_q;
  logic signed [CHANNEL_BITS:0] d_a, d_b, d_c;
  logic signed [CHANNEL_BITS:0] d_a_next, d_b_next, d_c_next;
  logic signed [2*CHANNEL_BITS+1:0] prod_a, prod_b, prod_c;
  logic [SQ_W-1:0]    sq_a, sq_b, sq_c;
  logic [DIST_W-1:0]  sum;
  logic [DIST_W-1:0]  best_d;
  logic [CENT_AW-1:0] best_idx;

  logic [TOTAL_W-1:0] change_counter;
  logic [TOTAL_W-1:0] cnt_base, change_counter_next;
  logic               point_ok, changed;
  logic               cent_ok;
  logic               wr_en;
  logic [PT_AW-1:0]   wr_addr;
  logic [CENT_AW-1:0] wr_data;

  assign cent_ok  = 32'(in_data.slot) < MAX_CENTROIDS;
  assign point_ok = 32'(slot_q) < MAX_POINTS;
  assign changed  = point_ok && (best_idx != prior_q);

  always_ff @(posedge clk) begin
    if (cmd.load_cent && cent_ok) begin
      cent_mem[in_data.slot[CENT_AW-1:0]] <= '{a: in_data.chan_a, b: in_data.chan_b,
                                              c: in_data.chan_c};
    end
    if (cmd.issue) begin
      cent_q <= cent_mem[cmd.issue_idx];
    end
  end

  // single write port shared by the clearing pass and the final update
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_q[PT_AW-1:0];
    wr_data = best_idx;
    if (cmd.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = cmd.clr_addr;
      wr_data = '0;
    end else if (cmd.finish && changed) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prior_mem[wr_addr] <= wr_data;
    end
    if (cmd.load_pt) begin
      prior_q <= prior_mem[in_data.slot[PT_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pt) begin
      pt     <= '{a: in_data.chan_a, b: in_data.chan_b, c: in_data.chan_c};
      slot_q <= in_data.slot;
      fob_q  <= in_data.first_of_batch;
    end
  end

  always_comb begin
    d_a_next = {pt.a[CHANNEL_BITS-1], pt.a} - {cent_q.a[CHANNEL_BITS-1], cent_q.a};
    d_b_next = {pt.b[CHANNEL_BITS-1], pt.b} - {cent_q.b[CHANNEL_BITS-1], cent_q.b};
    d_c_next = {pt.c[CHANNEL_BITS-1], pt.c} - {cent_q.c[CHANNEL_BITS-1], cent_q.c};
    prod_a   = d_a * d_a;
    prod_b   = d_b * d_b;
    prod_c   = d_c * d_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= cmd.issue;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    f0  <= cmd.issue_first;
    i0  <= cmd.issue_idx;
    f1  <= f0;
    i1  <= i0;
    d_a <= d_a_next;
    d_b <= d_b_next;
    d_c <= d_c_next;
    f2  <= f1;
    i2  <= i1;
    // squares are never negative, top bit of the product is always clear
    sq_a <= prod_a[SQ_W-1:0];
    sq_b <= prod_b[SQ_W-1:0];
    sq_c <= prod_c[SQ_W-1:0];
    f3  <= f2;
    i3  <= i2;
    sum <= DIST_W'(sq_a) + DIST_W'(sq_b) + DIST_W'(sq_c);
    // strict compare keeps the lower index on ties
    if (v3 && (f3 || sum < best_d)) begin
      best_d   <= sum;
      best_idx <= i3;
    end
  end

  always_comb begin
    cnt_base            = fob_q ? '0 : change_counter;
    change_counter_next = cnt_base;
    if (changed && cnt_base != TOTAL_MAX) begin
      change_counter_next = cnt_base + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      change_counter <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.finish) begin
        change_counter <= change_counter_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= '{nearest: best_idx, min_distance: best_d, was_changed: changed,
                    change_total: change_counter_next};
    end
  end

  assign status.busy     = v0 | v1 | v2 | v3;
  assign status.out_full = out_valid;

endmodule

>>> hdl/nca_ctrl.sv
// controller: clearing pass, centroid walk sequencing, config register
// uses nca_pkg
module nca_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [nca_pkg::CNT_W-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  nca_pkg::in_item_t        in_data,
  input  logic                     out_ready,
  input  nca_pkg::dp_status_t      status,
  output nca_pkg::dp_cmd_t         cmd
);
  import nca_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]         state, state_next;
  logic [CENT_AW-1:0] walk_idx, walk_idx_next;
  logic [PT_AW-1:0]   clr_addr, clr_addr_next;
  logic [CNT_W-1:0]   centroid_count;
  logic [CNT_W-1:0]   k_eff;
  logic [CENT_AW-1:0] last_idx;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      centroid_count <= CNT_W'(1);
    end else if (cfg_valid) begin
      centroid_count <= cfg_data;
    end
  end

  always_comb begin
    k_eff = centroid_count;
    if (centroid_count == '0) begin
      k_eff = CNT_W'(1);
    end else if (centroid_count > CNT_W'(MAX_CENTROIDS)) begin
      k_eff = CNT_W'(MAX_CENTROIDS);
    end
    last_idx = CENT_AW'(k_eff - 1'b1);
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    walk_idx_next = walk_idx;
    clr_addr_next = clr_addr;
    cmd           = '0;
    cmd.issue_idx = walk_idx;
    cmd.clr_addr  = clr_addr;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr    = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == PT_AW'(MAX_POINTS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_pt = 1'b1;
          if (in_data.opcode == OP_LOAD) begin
            cmd.load_cent = 1'b1;
          end else begin
            walk_idx_next = '0;
            state_next    = S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd.issue       = 1'b1;
        cmd.issue_first = (walk_idx == '0);
        walk_idx_next   = walk_idx + 1'b1;
        if (walk_idx == last_idx) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait for the output register to free up before committing
        if (!status.out_full || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      walk_idx <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      walk_idx <= walk_idx_next;
    end
  end

endmodule

>>> hdl/nearest_centroid_assign.sv
// Nearest centroid assignment (k-means assignment step) for three-channel signed points.
// A load transfer writes one centroid. An assign transfer walks centroids
// 0 .. k-1 through one shared distance pipeline, one centroid per cycle, where k is
// centroid_count held to 1 .. 16. An assign item holds off the next transfer until the
// walk and the four-stage pipeline drain are done and its result is written to the
// output register, where it sits, so a waiting result does not hold off the next item
// until its own result is ready. After reset the block clears the prior assignment
// memory, one entry per cycle, and takes no item during that pass; config writes are
// taken.
// Depends on nca_pkg, nca_ctrl and nca_datapath.
module nearest_centroid_assign (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [nca_pkg::CNT_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  nca_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output nca_pkg::out_item_t        out_data
);
  import nca_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  nca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  nca_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> hdl/nca_checker.sv
// port-level checks for nearest_centroid_assign, attached by bind
// uses nca_pkg and assert_macros.svh
`include "assert_macros.svh"

module nca_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic [nca_pkg::CNT_W-1:0] cfg_data,
  input logic                      in_valid,
  input logic                      in_ready,
  input nca_pkg::in_item_t         in_data,
  input logic                      out_valid,
  input logic                      out_ready,
  input nca_pkg::out_item_t        out_data
);
  import nca_pkg::*;

  `NCA_ASSERT(out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped")
  `NCA_ASSERT(out_stable, clk, rst, out_valid && !out_ready |=> $stable(out_data), "result changed while stalled")
  // the clearing pass must keep input closed right after reset
  `NCA_ASSERT_ALWAYS(clear_closed, clk, rst |=> !in_ready, "input open during clearing pass")
  `NCA_ASSERT(assign_busy, clk, rst, in_valid && in_ready && in_data.opcode == OP_ASSIGN |=> !in_ready, "second transfer during centroid walk")
  `NCA_ASSERT(count_nonzero, clk, rst, out_valid && out_data.was_changed |-> out_data.change_total != '0, "change not counted")

endmodule

bind nearest_centroid_assign nca_checker u_nca_checker (.*);
